// ===== src/hlc_pkg.sv =====
// ----------------------------------------------------------------------------
// hlc_pkg: shared types and constants for the hybrid logical clock
// Field widths, opcodes and the response record.
// ----------------------------------------------------------------------------
package hlc_pkg;

    localparam int OPCODE_W  = 2;
    localparam int LOGICAL_W = 42;
    localparam int COUNTER_W = 22;

    localparam logic [OPCODE_W-1:0] OP_BOOT   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_GET    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ADJUST = 2'd2;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

    typedef struct packed {
        logic [LOGICAL_W-1:0] logical;
        logic [COUNTER_W-1:0] counter;
        logic                 status;
    } rsp_t;

endpackage

// ===== src/hybrid_logical_clock.sv =====
// ----------------------------------------------------------------------------
// hybrid_logical_clock: logical millisecond clock with tie-break counter
// Boot, get-next-timestamp and adjust-to-remote requests, one response each.
// ----------------------------------------------------------------------------
// Every request is finished in the cycle it is accepted: compares, an
// increment and a select on the clock registers, written into a response
// register. One request can be accepted every cycle while the skid entry
// is empty. A single skid entry takes one more request while a response
// is stalled; req_stall rises only when that entry is full. State widths
// follow LOGICAL_BITS and COUNTER_BITS; port fields keep fixed widths and
// are truncated or zero-extended at the boundary.
module hybrid_logical_clock #(
    parameter int LOGICAL_BITS = 42,
    parameter int COUNTER_BITS = 22
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [hlc_pkg::OPCODE_W-1:0]  opcode,
    input  logic [hlc_pkg::LOGICAL_W-1:0] wall_time_ms,
    input  logic [hlc_pkg::LOGICAL_W-1:0] remote_logical,
    input  logic [hlc_pkg::COUNTER_W-1:0] remote_counter,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [hlc_pkg::LOGICAL_W-1:0] logical_out,
    output logic [hlc_pkg::COUNTER_W-1:0] counter_out,
    output logic                          status
);

    logic [LOGICAL_BITS-1:0] clock_logical_reg, clock_logical_next;
    logic [COUNTER_BITS-1:0] clock_counter_reg, clock_counter_next;
    logic                    initialized_reg, initialized_next;

    logic [63:0]             wall_ext, rlog_ext, rcnt_ext;
    logic [63:0]             log_ext, cnt_ext;
    logic [LOGICAL_BITS-1:0] wall;
    logic [LOGICAL_BITS-1:0] rlog;
    logic [COUNTER_BITS-1:0] rcnt;
    logic                    status_next;

    hlc_pkg::rsp_t rsp_new;
    hlc_pkg::rsp_t rsp_reg;
    hlc_pkg::rsp_t skid_reg;
    logic          rsp_valid_reg;
    logic          skid_valid_reg;
    logic          accept;
    logic          out_free;

    assign accept   = req_valid && !skid_valid_reg;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign wall_ext = 64'(wall_time_ms);
    assign rlog_ext = 64'(remote_logical);
    assign rcnt_ext = 64'(remote_counter);
    assign wall     = wall_ext[LOGICAL_BITS-1:0];
    assign rlog     = rlog_ext[LOGICAL_BITS-1:0];
    assign rcnt     = rcnt_ext[COUNTER_BITS-1:0];

    always_comb
    begin
        clock_logical_next = clock_logical_reg;
        clock_counter_next = clock_counter_reg;
        initialized_next   = initialized_reg;
        status_next        = hlc_pkg::ST_OK;
        case (opcode)
            hlc_pkg::OP_BOOT:
            begin
                if (!initialized_reg)
                begin
                    clock_logical_next = wall;
                    clock_counter_next = '0;
                    initialized_next   = 1'b1;
                end
            end
            hlc_pkg::OP_GET:
            begin
                if (clock_logical_reg == '0)
                begin
                    status_next = hlc_pkg::ST_REFUSED;
                end
                else if (clock_logical_reg < wall)
                begin
                    clock_logical_next = wall;
                    clock_counter_next = '0;
                end
                else if (clock_counter_reg == '1)
                begin
                    clock_logical_next = clock_logical_reg + LOGICAL_BITS'(1);
                    clock_counter_next = '0;
                end
                else
                begin
                    clock_counter_next = clock_counter_reg + COUNTER_BITS'(1);
                end
            end
            hlc_pkg::OP_ADJUST:
            begin
                if ((rlog > clock_logical_reg) ||
                    ((rlog == clock_logical_reg) && (rcnt > clock_counter_reg)))
                begin
                    clock_logical_next = rlog;
                    clock_counter_next = rcnt;
                end
            end
            default:
            begin
                status_next = hlc_pkg::ST_OK;
            end
        endcase
    end

    assign log_ext         = 64'(clock_logical_next);
    assign cnt_ext         = 64'(clock_counter_next);
    assign rsp_new.logical = log_ext[hlc_pkg::LOGICAL_W-1:0];
    assign rsp_new.counter = cnt_ext[hlc_pkg::COUNTER_W-1:0];
    assign rsp_new.status  = status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_logical_reg <= '0;
            clock_counter_reg <= '0;
            initialized_reg   <= 1'b0;
            rsp_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                clock_logical_reg <= clock_logical_next;
                clock_counter_reg <= clock_counter_next;
                initialized_reg   <= initialized_next;
            end
            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    rsp_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    rsp_valid_reg <= accept;
                end
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                rsp_reg <= skid_reg;
            end
            else if (accept)
            begin
                rsp_reg <= rsp_new;
            end
        end
        else if (accept)
        begin
            skid_reg <= rsp_new;
        end
    end

    assign req_stall   = skid_valid_reg;
    assign rsp_valid   = rsp_valid_reg;
    assign logical_out = rsp_reg.logical;
    assign counter_out = rsp_reg.counter;
    assign status      = rsp_reg.status;

endmodule

// ===== src/hlc_checker.sv =====
// ----------------------------------------------------------------------------
// hlc_port_checker: port-level checks for the hybrid logical clock
// Response hold, skid behaviour, latency and refusal consistency.
// ----------------------------------------------------------------------------
module hlc_port_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_stall,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic [hlc_pkg::LOGICAL_W-1:0] logical_out,
    input logic [hlc_pkg::COUNTER_W-1:0] counter_out,
    input logic                          status
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(logical_out) &&
            $stable(counter_out) && $stable(status)))
        else $error("stalled response changed");

    // request side stalls only behind a stalled response
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> $past(rsp_valid && rsp_stall))
        else $error("request stall without stalled response");

    // accepted request into an empty output shows next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && !rsp_valid) |=> rsp_valid)
        else $error("response missing one cycle after request");

    // refusal only when the clock reads zero
    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == hlc_pkg::ST_REFUSED)) |-> (logical_out == '0))
        else $error("refused get with non-zero clock");

endmodule

bind hybrid_logical_clock hlc_port_checker u_hlc_port_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .logical_out (logical_out),
    .counter_out (counter_out),
    .status      (status)
);
